### sv/ansi_key_escape_decoder_core_defines.svh
// Assertion macros for the escape key decoder.
// Used by the top level; expects clk and arst_n in scope.
`ifndef ANSI_KEY_ESCAPE_DECODER_CORE_DEFINES_SVH
`define ANSI_KEY_ESCAPE_DECODER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define AKD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("akd check failed");
`define AKD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("akd check failed");
`else
`define AKD_ASSERT_NOW(lbl, ante, cons)
`define AKD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### sv/akd_pkg.sv
// Shared types, constants and the key sequence table for the escape key decoder.
// No dependencies.
`default_nettype none
package akd_pkg;
	localparam int BYTE_W = 8;
	localparam int KIND_W = 2;
	localparam int KEY_W = 5;
	localparam int POS_W = 3;
	localparam int TABLE_ENTRIES = 32;
	localparam int SEQUENCE_BYTES = 6;
	localparam int STORED_ENTRIES = 27;
	localparam int STORED_BYTES = 4;
	localparam int ENTRY_LIMIT =
		(TABLE_ENTRIES < STORED_ENTRIES) ? TABLE_ENTRIES : STORED_ENTRIES;

	localparam logic [BYTE_W-1:0] KEY_ESC = 8'd27;
	localparam logic [BYTE_W-1:0] KEY_CSI = 8'h9b;
	localparam logic [BYTE_W-1:0] CHAR_NL = 8'd10;
	localparam logic [BYTE_W-1:0] CHAR_CR = 8'd13;
	localparam logic [BYTE_W-1:0] CHAR_BRACKET = 8'h5b;

	typedef enum logic [KIND_W-1:0] {
		KIND_CHAR = 2'd0,
		KIND_KEY = 2'd1,
		KIND_UNKNOWN = 2'd2
	} result_kind_t;

	typedef enum logic [1:0] {
		CLS_PLAIN = 2'd0,
		CLS_ESC = 2'd1,
		CLS_CSI = 2'd2
	} byte_class_t;

	typedef enum logic {
		BK_TAKE = 1'b0,
		BK_WALK = 1'b1
	} back_state_t;

	typedef struct packed {
		byte_class_t cls;
		logic [BYTE_W-1:0] byte_val;
		logic [BYTE_W-1:0] char_val;
	} akd_item_t;

	typedef struct packed {
		logic valid;
		akd_item_t item;
	} akd_head_t;

	localparam logic [BYTE_W-1:0] SEQ_ROM [STORED_ENTRIES][STORED_BYTES] = '{
		'{8'd27, "O", "A", 8'd0}, '{8'd27, "O", "B", 8'd0},
		'{8'd27, "O", "C", 8'd0}, '{8'd27, "O", "D", 8'd0},
		'{8'd27, "O", "M", 8'd0}, '{8'd27, "O", "P", 8'd0},
		'{8'd27, "O", "Q", 8'd0}, '{8'd27, "O", "R", 8'd0},
		'{8'd27, "O", "S", 8'd0}, '{8'd27, "O", "T", 8'd0},
		'{8'd27, "O", "l", 8'd0}, '{8'd27, "O", "m", 8'd0},
		'{8'd27, "O", "n", 8'd0}, '{8'd27, "O", "p", 8'd0},
		'{8'd27, "O", "q", 8'd0}, '{8'd27, "O", "r", 8'd0},
		'{8'd27, "O", "s", 8'd0}, '{8'd27, "O", "t", 8'd0},
		'{8'd27, "O", "u", 8'd0}, '{8'd27, "O", "v", 8'd0},
		'{8'd27, "O", "w", 8'd0}, '{8'd27, "O", "x", 8'd0},
		'{8'd27, "O", "y", 8'd0},
		'{8'd27, "[", "A", 8'd0}, '{8'd27, "[", "B", 8'd0},
		'{8'd27, "[", "C", 8'd0}, '{8'd27, "[", "D", 8'd0}
	};

	function automatic logic [BYTE_W-1:0] seq_byte(
		input logic [KEY_W-1:0] entry,
		input logic [POS_W-1:0] pos
	);
		if (int'(entry) >= ENTRY_LIMIT || int'(pos) >= STORED_BYTES ||
				int'(pos) >= SEQUENCE_BYTES) begin
			return '0;
		end
		return SEQ_ROM[entry][pos[1:0]];
	endfunction

	function automatic int csi_start();
		int cur;
		cur = 0;
		while (cur < ENTRY_LIMIT && SEQ_ROM[cur][0] < KEY_ESC) begin
			cur++;
		end
		while (cur < ENTRY_LIMIT && SEQ_ROM[cur][1] < CHAR_BRACKET) begin
			cur++;
		end
		return cur;
	endfunction

	localparam logic [KEY_W-1:0] LIMIT_KEY = KEY_W'(ENTRY_LIMIT);
	localparam logic [KEY_W-1:0] CSI_START = KEY_W'(csi_start());
endpackage
`default_nettype wire

### sv/akd_key_if.sv
// Input channel carrying one keyboard byte per beat.
// Depends on akd_pkg.
`default_nettype none
interface akd_key_if;
	logic valid;
	logic ready;
	logic [akd_pkg::BYTE_W-1:0] key_byte;
	modport source(output valid, output key_byte, input ready);
	modport sink(input valid, input key_byte, output ready);
endinterface
`default_nettype wire

### sv/akd_result_if.sv
// Output channel carrying one decoded result per beat.
// Depends on akd_pkg.
`default_nettype none
interface akd_result_if;
	logic valid;
	logic ready;
	logic [akd_pkg::KIND_W-1:0] result_kind;
	logic [akd_pkg::BYTE_W-1:0] char_value;
	logic [akd_pkg::KEY_W-1:0] key_number;
	modport source(output valid, output result_kind, output char_value,
		output key_number, input ready);
	modport sink(input valid, input result_kind, input char_value,
		input key_number, output ready);
endinterface
`default_nettype wire

### sv/akd_front.sv
// Front end: accepts key bytes, classifies them and queues them two deep.
// Depends on akd_pkg and akd_key_if.
`default_nettype none
module akd_front (
	input logic clk,
	input logic arst_n,
	akd_key_if.sink keys,
	output akd_pkg::akd_head_t head,
	input logic pop
);
	akd_pkg::akd_item_t mem_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	akd_pkg::akd_item_t item_in;
	logic push;

	always_comb begin
		item_in.byte_val = keys.key_byte;
		item_in.char_val = (keys.key_byte == akd_pkg::CHAR_NL) ? akd_pkg::CHAR_CR
			: keys.key_byte;
		if (keys.key_byte == akd_pkg::KEY_ESC) begin
			item_in.cls = akd_pkg::CLS_ESC;
		end else if (keys.key_byte == akd_pkg::KEY_CSI) begin
			item_in.cls = akd_pkg::CLS_CSI;
		end else begin
			item_in.cls = akd_pkg::CLS_PLAIN;
		end
	end

	assign keys.ready = (count_q != 2'd2);
	assign push = keys.valid && keys.ready;
	assign head.valid = (count_q != 2'd0);
	assign head.item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule
`default_nettype wire

### sv/akd_back.sv
// Back end: tracks the escape sequence, walks the key table one entry per cycle
// and holds the result register. Depends on akd_pkg and akd_result_if.
`default_nettype none
module akd_back (
	input logic clk,
	input logic arst_n,
	input akd_pkg::akd_head_t head,
	output logic pop,
	akd_result_if.source results
);
	akd_pkg::back_state_t state_q, state_d;
	logic in_seq_q, in_seq_d;
	logic [akd_pkg::POS_W-1:0] pos_q, pos_d;
	logic [akd_pkg::KEY_W-1:0] cur_q, cur_d;
	logic [akd_pkg::BYTE_W-1:0] byte_q, byte_d;
	logic out_valid_q;
	akd_pkg::result_kind_t out_kind_q;
	logic [akd_pkg::BYTE_W-1:0] out_char_q;
	logic [akd_pkg::KEY_W-1:0] out_key_q;
	logic slot_free;
	logic emit;
	akd_pkg::result_kind_t emit_kind;
	logic [akd_pkg::BYTE_W-1:0] emit_char;
	logic [akd_pkg::KEY_W-1:0] emit_key;
	logic [akd_pkg::BYTE_W-1:0] entry_byte;
	logic [akd_pkg::BYTE_W-1:0] next_byte;

	assign slot_free = !out_valid_q || results.ready;
	assign entry_byte = akd_pkg::seq_byte(cur_q, pos_q);
	assign next_byte = akd_pkg::seq_byte(cur_q, pos_q + 3'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= akd_pkg::BK_TAKE;
			in_seq_q <= 1'b0;
			pos_q <= '0;
			cur_q <= '0;
		end else begin
			state_q <= state_d;
			in_seq_q <= in_seq_d;
			pos_q <= pos_d;
			cur_q <= cur_d;
		end
	end

	always_ff @(posedge clk) begin
		byte_q <= byte_d;
	end

	always_comb begin
		state_d = state_q;
		in_seq_d = in_seq_q;
		pos_d = pos_q;
		cur_d = cur_q;
		byte_d = byte_q;
		pop = 1'b0;
		emit = 1'b0;
		emit_kind = akd_pkg::KIND_CHAR;
		emit_char = '0;
		emit_key = '0;
		unique case (state_q)
			akd_pkg::BK_TAKE: begin
				if (head.valid && slot_free) begin
					pop = 1'b1;
					if (!in_seq_q) begin
						unique case (head.item.cls)
							akd_pkg::CLS_ESC: begin
								in_seq_d = 1'b1;
								pos_d = '0;
								cur_d = '0;
							end
							akd_pkg::CLS_CSI: begin
								in_seq_d = 1'b1;
								pos_d = 3'd1;
								cur_d = akd_pkg::CSI_START;
							end
							default: begin
								emit = 1'b1;
								emit_kind = akd_pkg::KIND_CHAR;
								emit_char = head.item.char_val;
							end
						endcase
					end else begin
						byte_d = head.item.byte_val;
						pos_d = pos_q + 3'd1;
						state_d = akd_pkg::BK_WALK;
					end
				end
			end
			akd_pkg::BK_WALK: begin
				if (cur_q >= akd_pkg::LIMIT_KEY || entry_byte > byte_q) begin
					if (slot_free) begin
						emit = 1'b1;
						emit_kind = akd_pkg::KIND_UNKNOWN;
						in_seq_d = 1'b0;
						pos_d = '0;
						cur_d = '0;
						state_d = akd_pkg::BK_TAKE;
					end
				end else if (entry_byte < byte_q) begin
					cur_d = cur_q + 5'd1;
				end else if (pos_q == 3'd7 || next_byte == '0) begin
					if (slot_free) begin
						emit = 1'b1;
						emit_kind = akd_pkg::KIND_KEY;
						emit_key = cur_q;
						in_seq_d = 1'b0;
						pos_d = '0;
						cur_d = '0;
						state_d = akd_pkg::BK_TAKE;
					end
				end else begin
					state_d = akd_pkg::BK_TAKE;
				end
			end
			default: state_d = akd_pkg::BK_TAKE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_kind_q <= emit_kind;
			out_char_q <= emit_char;
			out_key_q <= emit_key;
		end
	end

	assign results.valid = out_valid_q;
	assign results.result_kind = out_kind_q;
	assign results.char_value = out_char_q;
	assign results.key_number = out_key_q;
endmodule
`default_nettype wire

### sv/ansi_key_escape_decoder_core.sv
// Escape key decoder: a plain byte leaves as a character (newline as carriage
// return); ESC or CSI opens a sequence that is looked up in a fixed table of 27 keys.
// A plain byte passes through the front queue into the result register; a byte
// inside a sequence is taken by the back end's table walk, which checks one cursor
// position at a time, the end of the table included, before it emits a result or
// takes the next byte. The back end takes a byte only while the result
// register is free. A two-beat queue sits between the front and back ends.
// Depends on akd_pkg, akd_key_if, akd_result_if, akd_front and akd_back.
`default_nettype none
`include "ansi_key_escape_decoder_core_defines.svh"
module ansi_key_escape_decoder_core (
	input logic clk,
	input logic arst_n,
	akd_key_if.sink keys,
	akd_result_if.source results
);
	akd_pkg::akd_head_t head;
	logic pop;

	akd_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.keys(keys),
		.head(head),
		.pop(pop)
	);

	akd_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.pop(pop),
		.results(results)
	);

	`AKD_ASSERT_NOW(a_pop_has_head, pop, head.valid)
	`AKD_ASSERT_NOW(a_key_only_on_match,
		results.valid && results.result_kind != akd_pkg::KIND_KEY,
		results.key_number == '0)
	`AKD_ASSERT_NOW(a_char_only_plain,
		results.valid && results.result_kind != akd_pkg::KIND_CHAR,
		results.char_value == '0)
	`AKD_ASSERT_NEXT(a_full_queue_stalls,
		!keys.ready && !pop, !keys.ready)
endmodule
`default_nettype wire

### tb/ansi_key_escape_decoder_core_tb.sv
// Self-checking bench for the escape key decoder: directed and random keyboard bytes,
// decodes predicted on each accepted beat and compared beat by beat.
// Depends on akd_pkg, akd_key_if, akd_result_if and ansi_key_escape_decoder_core.
module ansi_key_escape_decoder_core_tb;
	localparam int KEYPAD_KEYS = 23;
	localparam int KNOWN_KEYS = 27;
	localparam int LAST_KEY_POS = 3;
	localparam int ENTRIES_PRESENT = (akd_pkg::TABLE_ENTRIES < KNOWN_KEYS) ?
		akd_pkg::TABLE_ENTRIES : KNOWN_KEYS;
	localparam int TOTAL_BYTES = 1850;
	localparam int HOLD_CYCLES = 400;
	localparam int LONE_GAP = 150;
	localparam int STALL_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 40;
	localparam logic [akd_pkg::BYTE_W-1:0] INTRO_SS3 = "O";

	localparam logic [akd_pkg::BYTE_W-1:0] KEY_FINALS [KNOWN_KEYS] = '{
		"A", "B", "C", "D", "M", "P", "Q", "R", "S", "T", "l", "m", "n", "p",
		"q", "r", "s", "t", "u", "v", "w", "x", "y",
		"A", "B", "C", "D"
	};

	typedef struct packed {
		akd_pkg::result_kind_t kind;
		logic [akd_pkg::BYTE_W-1:0] ch;
		logic [akd_pkg::KEY_W-1:0] key;
	} decode_t;

	logic clk = 1'b0;
	logic arst_n;

	akd_key_if keys();
	akd_result_if results();

	ansi_key_escape_decoder_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.keys(keys),
		.results(results)
	);

	logic seq_open;
	logic [akd_pkg::POS_W-1:0] seq_pos;
	logic [akd_pkg::KEY_W-1:0] seq_entry;
	decode_t expected_decodes [$];
	int error_count;
	int bytes_sent;
	int burst_left;
	int forced_gap;
	int stall_cycles;
	bit hold_req;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [akd_pkg::BYTE_W-1:0] table_byte(input int entry,
			input int pos);
		if (entry >= ENTRIES_PRESENT || pos > LAST_KEY_POS ||
				pos >= akd_pkg::SEQUENCE_BYTES) begin
			return '0;
		end
		case (pos)
			0: return akd_pkg::KEY_ESC;
			1: return (entry < KEYPAD_KEYS) ? INTRO_SS3 : akd_pkg::CHAR_BRACKET;
			2: return KEY_FINALS[entry];
			default: return '0;
		endcase
	endfunction

	function automatic bit decode_key_byte(input logic [akd_pkg::BYTE_W-1:0] b,
			output decode_t res);
		int walk;
		logic [akd_pkg::POS_W-1:0] p;
		logic [akd_pkg::POS_W-1:0] p_next;
		logic [akd_pkg::BYTE_W-1:0] nxt;
		res.kind = akd_pkg::KIND_CHAR;
		res.ch = '0;
		res.key = '0;
		if (!seq_open) begin
			if (b == akd_pkg::KEY_ESC) begin
				seq_open = 1'b1;
				seq_pos = '0;
				seq_entry = '0;
				return 1'b0;
			end
			if (b == akd_pkg::KEY_CSI) begin
				walk = 0;
				while (walk < ENTRIES_PRESENT && table_byte(walk, 0) < akd_pkg::KEY_ESC)
					walk++;
				while (walk < ENTRIES_PRESENT &&
						table_byte(walk, 1) < akd_pkg::CHAR_BRACKET)
					walk++;
				seq_open = 1'b1;
				seq_pos = akd_pkg::POS_W'(1);
				seq_entry = akd_pkg::KEY_W'(walk);
				return 1'b0;
			end
			res.ch = (b == akd_pkg::CHAR_NL) ? akd_pkg::CHAR_CR : b;
			return 1'b1;
		end
		p = seq_pos + 1'b1;
		p_next = p + 1'b1;
		walk = int'(seq_entry);
		while (walk < ENTRIES_PRESENT && table_byte(walk, int'(p)) < b) walk++;
		if (walk >= ENTRIES_PRESENT || table_byte(walk, int'(p)) > b) begin
			seq_open = 1'b0;
			seq_pos = '0;
			seq_entry = '0;
			res.kind = akd_pkg::KIND_UNKNOWN;
			return 1'b1;
		end
		nxt = table_byte(walk, int'(p_next));
		if (p == '1 || nxt == '0) begin
			seq_open = 1'b0;
			seq_pos = '0;
			seq_entry = '0;
			res.kind = akd_pkg::KIND_KEY;
			res.key = akd_pkg::KEY_W'(walk);
			return 1'b1;
		end
		seq_pos = p;
		seq_entry = akd_pkg::KEY_W'(walk);
		return 1'b0;
	endfunction

	task automatic report_mismatch(input string what, input int got_val, input int exp_val);
		$display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got_val, exp_val);
		error_count++;
	endtask

	task automatic send_byte(input logic [akd_pkg::BYTE_W-1:0] b);
		decode_t res;
		bit has_result;
		int gap;
		if (burst_left == 0) begin
			if (forced_gap > 0) begin
				gap = forced_gap;
			end else begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			end
			forced_gap = 0;
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				keys.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		keys.valid <= 1'b1;
		keys.key_byte <= b;
		do @(posedge clk); while (!keys.ready);
		has_result = decode_key_byte(b, res);
		if (has_result) expected_decodes.push_back(res);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_key(input int k, input bit via_csi);
		if (via_csi && k >= KEYPAD_KEYS) begin
			send_byte(akd_pkg::KEY_CSI);
		end else begin
			send_byte(akd_pkg::KEY_ESC);
			send_byte(table_byte(k, 1));
		end
		send_byte(table_byte(k, 2));
	endtask

	task automatic test_plain_bytes();
		send_byte(8'h00);
		send_byte(8'hff);
		send_byte(akd_pkg::CHAR_NL);
	endtask

	task automatic test_keypad_keys();
		send_key(0, 1'b0);
		send_key(KEYPAD_KEYS - 1, 1'b0);
	endtask

	task automatic test_cursor_keys();
		send_key(KEYPAD_KEYS + 1, 1'b0);
		send_key(KNOWN_KEYS - 1, 1'b1);
	endtask

	task automatic test_mismatches();
		send_byte(akd_pkg::KEY_ESC);
		send_byte(INTRO_SS3);
		send_byte("N");
		send_byte(akd_pkg::KEY_ESC);
		send_byte(INTRO_SS3);
		send_byte("z");
		send_byte(akd_pkg::KEY_CSI);
		send_byte("E");
		send_byte(akd_pkg::KEY_ESC);
		send_byte(akd_pkg::KEY_ESC);
	endtask

	task automatic test_lone_escape();
		send_byte(akd_pkg::KEY_ESC);
		burst_left = 0;
		forced_gap = LONE_GAP;
		send_byte(INTRO_SS3);
		send_byte("M");
	endtask

	task automatic test_backpressure();
		hold_req = 1'b1;
		repeat (40) send_byte(8'($urandom_range(32, 126)));
	endtask

	task automatic test_random_traffic();
		int pick;
		int k;
		while (bytes_sent < TOTAL_BYTES) begin
			pick = $urandom_range(0, 99);
			k = $urandom_range(0, KNOWN_KEYS - 1);
			if (pick < 55) begin
				send_key(k, $urandom_range(0, 1) == 1);
			end else if (pick < 60) begin
				send_byte(akd_pkg::CHAR_NL);
			end else if (pick < 75) begin
				send_byte(8'($urandom_range(0, 255)));
			end else if (pick < 92) begin
				case ($urandom_range(0, 3))
					0: send_byte(akd_pkg::KEY_ESC);
					1: send_byte(akd_pkg::KEY_CSI);
					2: begin
						send_byte(akd_pkg::KEY_ESC);
						send_byte(INTRO_SS3);
					end
					default: begin
						send_byte(akd_pkg::KEY_ESC);
						send_byte(akd_pkg::CHAR_BRACKET);
					end
				endcase
				send_byte(8'($urandom_range(0, 255)));
			end else begin
				send_byte(8'($urandom_range(0, 255)));
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		keys.valid <= 1'b0;
		keys.key_byte <= '0;
		seq_open = 1'b0;
		seq_pos = '0;
		seq_entry = '0;
		error_count = 0;
		bytes_sent = 0;
		burst_left = 0;
		forced_gap = 0;
		hold_req = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_plain_bytes();
		test_keypad_keys();
		test_cursor_keys();
		test_mismatches();
		test_lone_escape();
		test_backpressure();
		test_random_traffic();
		keys.valid <= 1'b0;
		while (expected_decodes.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin : result_pacer
		int stretch_left;
		int pace_mode;
		int hold_left;
		int tick;
		stretch_left = 0;
		pace_mode = 0;
		hold_left = 0;
		tick = 0;
		results.ready <= 1'b0;
		forever begin
			@(negedge clk);
			tick++;
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				results.ready <= 1'b0;
			end else begin
				if (stretch_left == 0) begin
					stretch_left = $urandom_range(8, 80);
					pace_mode = $urandom_range(0, 3);
				end
				stretch_left--;
				case (pace_mode)
					0: results.ready <= 1'b1;
					1: results.ready <= ($urandom_range(0, 1) == 1);
					2: results.ready <= (tick % 5) != 0;
					default: results.ready <= (tick % 16) < 4;
				endcase
			end
		end
	end

	always @(posedge clk) begin : result_check
		decode_t want;
		if (arst_n && results.valid && results.ready) begin
			if (expected_decodes.size() == 0) begin
				report_mismatch("result beat with nothing pending", results.result_kind, 0);
			end else begin
				want = expected_decodes.pop_front();
				if (results.result_kind !== want.kind) begin
					report_mismatch("result_kind", results.result_kind, want.kind);
				end
				if (results.char_value !== want.ch) begin
					report_mismatch("char_value", results.char_value, want.ch);
				end
				if (results.key_number !== want.key) begin
					report_mismatch("key_number", results.key_number, want.key);
				end
			end
		end
	end

	initial stall_cycles = 0;

	always @(posedge clk) begin
		if ((keys.valid && keys.ready) || (results.valid && results.ready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end
endmodule

### files.f
+incdir+sv
sv/akd_pkg.sv
sv/akd_key_if.sv
sv/akd_result_if.sv
sv/akd_front.sv
sv/akd_back.sv
sv/ansi_key_escape_decoder_core.sv
tb/ansi_key_escape_decoder_core_tb.sv
